@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is held.
`define UCRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UCRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ucrs_pkg.sv @@
// Shared types, codes and field layout of the Unicode category range search.
`timescale 1ns / 1ps

package ucrs_pkg;

    // Default sizes of the range tables and gap tables (per plane)
    localparam int unsigned MAX_RANGES_DEF = 512;
    localparam int unsigned GAP_DEPTH_DEF  = 32768;

    // Field widths
    localparam int CP_W      = 21;
    localparam int CAT_W     = 8;
    localparam int IDX_W     = 15;
    localparam int CNT_W     = 10;
    localparam int REQ_W     = 2;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_RANGE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WR_GAP   = 2'd2;

    // Lookup status codes
    localparam logic [ST_W-1:0] ST_RANGE = 2'd0;
    localparam logic [ST_W-1:0] ST_GAP   = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASIC_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPP_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNASSIGNED  = 2'd2;

    // First code point of the supplementary planes, one bit wider than a code point
    localparam logic [CP_W:0] PLANE_BASE = 22'h010000;

    // Request stream layout
    localparam int S_TDATA_W   = 120;
    localparam int S_TUSER_W   = 3;
    localparam int OFS_ENTRY   = 0;
    localparam int OFS_RSTART  = 15;
    localparam int OFS_REND    = 36;
    localparam int OFS_GOFF    = 57;
    localparam int OFS_RCAT    = 78;
    localparam int OFS_GCAT    = 86;
    localparam int OFS_CP      = 94;
    localparam int OFS_REQ     = 0;
    localparam int OFS_PLANE   = 2;

    // Result stream layout
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // One range table entry
    typedef struct packed {
        logic [CP_W-1:0]  first_cp;
        logic [CP_W-1:0]  last_cp;
        logic [CP_W-1:0]  gap_off;
        logic [CAT_W-1:0] cat;
    } t_range_entry;

    // Everything one search probe needs: entry i and the bounds of its neighbors
    typedef struct packed {
        logic [CP_W-1:0]  first_i;
        logic [CP_W-1:0]  first_next;
        logic [CP_W-1:0]  last_prev;
        logic [CP_W-1:0]  last_i;
        logic [CP_W-1:0]  off_prev;
        logic [CP_W-1:0]  off_i;
        logic [CAT_W-1:0] cat_i;
    } t_probe;

endpackage

@@ rtl/ucrs_range_mem.sv @@
// Range table memories of both planes, read as entry i with its two neighbors.
`timescale 1ns / 1ps

module ucrs_range_mem #(
    parameter int unsigned MAX_RANGES = ucrs_pkg::MAX_RANGES_DEF,
    localparam int IW = $clog2(MAX_RANGES),
    localparam int AW = IW + 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,   // {plane, index}
    input  ucrs_pkg::t_range_entry i_wr_entry,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,   // {plane, index}
    output ucrs_pkg::t_probe      o_probe
);

    localparam int DEPTH = 2 ** AW;

    logic [ucrs_pkg::CP_W-1:0]  r_first_mem [0:DEPTH-1];
    logic [ucrs_pkg::CP_W-1:0]  r_last_mem  [0:DEPTH-1];
    logic [ucrs_pkg::CP_W-1:0]  r_off_mem   [0:DEPTH-1];
    logic [ucrs_pkg::CAT_W-1:0] r_cat_mem   [0:DEPTH-1];
    ucrs_pkg::t_probe           r_probe;

    logic          w_plane;
    logic [IW-1:0] w_idx;
    logic [AW-1:0] w_addr_prev;
    logic [AW-1:0] w_addr_next;

    // Neighbor addresses stay inside the plane; a wrapped one is never used
    assign w_plane     = i_rd_addr[IW];
    assign w_idx       = i_rd_addr[IW-1:0];
    assign w_addr_prev = {w_plane, w_idx - IW'(1)};
    assign w_addr_next = {w_plane, w_idx + IW'(1)};

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_first_mem[i_wr_addr] <= i_wr_entry.first_cp;
            r_last_mem[i_wr_addr]  <= i_wr_entry.last_cp;
            r_off_mem[i_wr_addr]   <= i_wr_entry.gap_off;
            r_cat_mem[i_wr_addr]   <= i_wr_entry.cat;
        end
    end

    // Registered read ports, two per memory at most
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_probe.first_i    <= r_first_mem[i_rd_addr];
            r_probe.first_next <= r_first_mem[w_addr_next];
            r_probe.last_prev  <= r_last_mem[w_addr_prev];
            r_probe.last_i     <= r_last_mem[i_rd_addr];
            r_probe.off_prev   <= r_off_mem[w_addr_prev];
            r_probe.off_i      <= r_off_mem[i_rd_addr];
            r_probe.cat_i      <= r_cat_mem[i_rd_addr];
        end
    end

    assign o_probe = r_probe;

endmodule

@@ rtl/unicode_category_range_search.sv @@
// Top level: Unicode category lookup by skewed search over per-plane range tables.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: request fields, tuser: kind, plane
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: category, tuser: status
//   cfg       in   i_cfg_we                      i_cfg_index, i_cfg_wdata
//
// A table write does not leave the idle state. Each search probe is a range memory read,
// then a compare; a lookup makes up to about log4/3 of the range count plus one probes (about 23
// for 512 ranges); a gap table read, setup and hand-off add further steps.
// No clearing pass after reset: table contents are undefined until written.
// A result waits in the output register while the next request is taken; a further
// lookup result then holds in the final state until the output register frees.
`timescale 1ns / 1ps

module unicode_category_range_search #(
    parameter int unsigned MAX_RANGES = ucrs_pkg::MAX_RANGES_DEF,
    parameter int unsigned GAP_DEPTH  = ucrs_pkg::GAP_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ucrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ucrs_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index, range_start, range_end, gap_offset, range_category,
    // gap_category, code_point, zero pad
    input  logic [ucrs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // req_type, plane_select
    input  logic [ucrs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // category
    output logic [ucrs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // lookup_status
    output logic [ucrs_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int IW    = $clog2(MAX_RANGES);
    localparam int AW    = IW + 1;
    localparam int CW    = $clog2(MAX_RANGES + 1);
    localparam int NW    = (CW > ucrs_pkg::CNT_W) ? CW : ucrs_pkg::CNT_W;
    localparam int GW    = $clog2(GAP_DEPTH);
    localparam int GAW   = GW + 1;
    localparam int EXT_W = ucrs_pkg::IDX_W + 2;
    localparam int DW    = ucrs_pkg::CP_W + 1;
    localparam int CPW   = ucrs_pkg::CP_W;
    localparam int CATW  = ucrs_pkg::CAT_W;

    localparam logic [NW-1:0]    MAX_N      = NW'(MAX_RANGES);
    localparam logic [CW-1:0]    MAX_N_C    = CW'(MAX_RANGES);
    localparam logic [EXT_W-1:0] RANGE_LIM  = EXT_W'(MAX_RANGES);
    localparam logic [EXT_W-1:0] GAP_LIM    = EXT_W'(GAP_DEPTH);
    localparam logic [DW-1:0]    GAP_LIM_D  = DW'(GAP_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CMP  = 6'b000100,
        S_GIDX = 6'b001000,
        S_GRD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // Request fields
    logic [ucrs_pkg::REQ_W-1:0] w_req;
    logic                       w_wplane;
    logic [ucrs_pkg::IDX_W-1:0] w_entry;
    logic [EXT_W-1:0]           w_entry_ext;
    logic [CPW-1:0]             w_cp;
    logic                       w_in_acc;
    ucrs_pkg::t_range_entry     w_wr_entry;

    // Configuration
    logic [ucrs_pkg::CNT_W-1:0] r_basic_cnt;
    logic [ucrs_pkg::CNT_W-1:0] r_supp_cnt;
    logic [CATW-1:0]            r_unassigned;

    // Search state
    t_state                  r_state, n_state;
    logic [CPW-1:0]          r_cp, n_cp;
    logic                    r_plane, n_plane;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hx, n_hx;      // one past the last open entry
    logic [CW-1:0]           r_n, n_n;
    logic [IW-1:0]           r_idx, n_idx;
    logic [CPW-1:0]          r_off, n_off;
    logic [CATW-1:0]         r_cat, n_cat;
    logic [ucrs_pkg::ST_W-1:0] r_st, n_st;

    // Output register
    logic                      r_out_valid;
    logic [CATW-1:0]           r_out_cat;
    logic [ucrs_pkg::ST_W-1:0] r_out_st;

    // Memory ports
    logic                    w_rng_we;
    logic                    w_rng_rd_en;
    ucrs_pkg::t_probe        w_probe;
    logic                    w_gap_we;
    logic                    w_gap_rd_en;
    logic [GAW-1:0]          w_gap_rd_addr;
    logic [CATW-1:0]         r_gap_mem [0:(2 ** GAW)-1];
    logic [CATW-1:0]         r_gap_rd;

    // Datapath helpers
    logic                    w_cp_plane;
    logic [ucrs_pkg::CNT_W-1:0] w_cnt_sel;
    logic [NW-1:0]           w_cnt_ext;
    logic [CW-1:0]           w_n_lim;
    logic [CW-1:0]           w_span;
    logic [CW-1:0]           w_mid;
    logic [AW-1:0]           w_rd_addr;
    logic [CW-1:0]           w_idx_c;
    logic [CW-1:0]           w_idx_inc;
    logic [DW-1:0]           w_gbase;
    logic [DW-1:0]           w_cp_ext;
    logic [DW-1:0]           w_gdiff;
    logic                    w_gap_ok;
    logic                    w_out_load;

    // Unpack the request stream
    assign w_req       = s_axis_tuser[ucrs_pkg::OFS_REQ +: ucrs_pkg::REQ_W];
    assign w_wplane    = s_axis_tuser[ucrs_pkg::OFS_PLANE];
    assign w_entry     = s_axis_tdata[ucrs_pkg::OFS_ENTRY +: ucrs_pkg::IDX_W];
    assign w_entry_ext = {2'b00, w_entry};
    assign w_cp        = s_axis_tdata[ucrs_pkg::OFS_CP +: CPW];
    assign w_wr_entry.first_cp = s_axis_tdata[ucrs_pkg::OFS_RSTART +: CPW];
    assign w_wr_entry.last_cp  = s_axis_tdata[ucrs_pkg::OFS_REND +: CPW];
    assign w_wr_entry.gap_off  = s_axis_tdata[ucrs_pkg::OFS_GOFF +: CPW];
    assign w_wr_entry.cat      = s_axis_tdata[ucrs_pkg::OFS_RCAT +: CATW];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;

    // Table writes, out-of-range indexes dropped
    assign w_rng_we = w_in_acc && (w_req == ucrs_pkg::REQ_WR_RANGE) && (w_entry_ext < RANGE_LIM);
    assign w_gap_we = w_in_acc && (w_req == ucrs_pkg::REQ_WR_GAP) && (w_entry_ext < GAP_LIM);

    // Plane and range count of a new lookup, count clamped to the table size
    assign w_cp_plane = ({1'b0, w_cp} >= ucrs_pkg::PLANE_BASE);
    assign w_cnt_sel  = w_cp_plane ? r_supp_cnt : r_basic_cnt;
    assign w_cnt_ext  = NW'(w_cnt_sel);
    assign w_n_lim    = (w_cnt_ext > MAX_N) ? MAX_N_C : w_cnt_ext[CW-1:0];

    // Probe a quarter of the way into the open interval
    assign w_span    = r_hx - r_lo - CW'(1);
    assign w_mid     = r_lo + (w_span >> 2);
    assign w_rd_addr = {r_plane, w_mid[IW-1:0]};
    assign w_idx_c   = CW'(r_idx);
    assign w_idx_inc = w_idx_c + CW'(1);

    // Gap table index and bounds check
    assign w_gbase  = {1'b0, r_off} + (r_plane ? ucrs_pkg::PLANE_BASE : DW'(0));
    assign w_cp_ext = {1'b0, r_cp};
    assign w_gdiff  = w_cp_ext - w_gbase;
    assign w_gap_ok = (w_cp_ext >= w_gbase) && (w_gdiff < GAP_LIM_D);
    assign w_gap_rd_addr = {r_plane, w_gdiff[GW-1:0]};

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Search sequencer
    always_comb begin
        n_state     = r_state;
        n_cp        = r_cp;
        n_plane     = r_plane;
        n_lo        = r_lo;
        n_hx        = r_hx;
        n_n         = r_n;
        n_idx       = r_idx;
        n_off       = r_off;
        n_cat       = r_cat;
        n_st        = r_st;
        w_rng_rd_en = 1'b0;
        w_gap_rd_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (w_req == ucrs_pkg::REQ_LOOKUP)) begin
                    n_cp    = w_cp;
                    n_plane = w_cp_plane;
                    n_lo    = '0;
                    n_hx    = w_n_lim;
                    n_n     = w_n_lim;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_lo < r_hx) begin
                    n_idx       = w_mid[IW-1:0];
                    w_rng_rd_en = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    // empty table or search exhausted
                    n_st    = ucrs_pkg::ST_NONE;
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                priority if (r_cp < w_probe.first_i) begin
                    priority if (r_idx == '0) begin
                        n_st    = ucrs_pkg::ST_NONE;
                        n_state = S_DONE;
                    end else if (r_cp > w_probe.last_prev) begin
                        n_off   = w_probe.off_prev;
                        n_state = S_GIDX;
                    end else begin
                        n_hx    = w_idx_c;
                        n_state = S_READ;
                    end
                end else if (r_cp > w_probe.last_i) begin
                    if ((w_idx_inc == r_n) || (r_cp < w_probe.first_next)) begin
                        n_off   = w_probe.off_i;
                        n_state = S_GIDX;
                    end else begin
                        n_lo    = w_idx_inc;
                        n_state = S_READ;
                    end
                end else begin
                    n_cat   = w_probe.cat_i;
                    n_st    = ucrs_pkg::ST_RANGE;
                    n_state = S_DONE;
                end
            end
            S_GIDX: begin
                if (w_gap_ok) begin
                    w_gap_rd_en = 1'b1;
                    n_state     = S_GRD;
                end else begin
                    n_st    = ucrs_pkg::ST_NONE;
                    n_state = S_DONE;
                end
            end
            S_GRD: begin
                n_cat   = r_gap_rd;
                n_st    = ucrs_pkg::ST_GAP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_basic_cnt  <= '0;
            r_supp_cnt   <= '0;
            r_unassigned <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ucrs_pkg::CFG_BASIC_COUNT: r_basic_cnt  <= i_cfg_wdata;
                    ucrs_pkg::CFG_SUPP_COUNT:  r_supp_cnt   <= i_cfg_wdata;
                    ucrs_pkg::CFG_UNASSIGNED:  r_unassigned <= i_cfg_wdata[CATW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Search and result payload
    always_ff @(posedge i_clk) begin
        r_cp    <= n_cp;
        r_plane <= n_plane;
        r_lo    <= n_lo;
        r_hx    <= n_hx;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_off   <= n_off;
        r_cat   <= n_cat;
        r_st    <= n_st;
        if (w_out_load) begin
            r_out_cat <= (r_st == ucrs_pkg::ST_NONE) ? r_unassigned : r_cat;
            r_out_st  <= r_st;
        end
    end

    // Gap tables of both planes
    always_ff @(posedge i_clk) begin
        if (w_gap_we) begin
            r_gap_mem[{w_wplane, w_entry_ext[GW-1:0]}] <= s_axis_tdata[ucrs_pkg::OFS_GCAT +: CATW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gap_rd_en) begin
            r_gap_rd <= r_gap_mem[w_gap_rd_addr];
        end
    end

    ucrs_range_mem #(
        .MAX_RANGES (MAX_RANGES)
    ) u_range_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_rng_we),
        .i_wr_addr  ({w_wplane, w_entry[IW-1:0]}),
        .i_wr_entry (w_wr_entry),
        .i_rd_en    (w_rng_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_probe    (w_probe)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_cat;
    assign m_axis_tuser  = r_out_st;

endmodule

@@ rtl/ucrs_checker.sv @@
// Port-level checker of the category range search, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucrs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [ucrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [ucrs_pkg::CFG_W-1:0]      i_cfg_wdata,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ucrs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [ucrs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ucrs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [ucrs_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    logic w_in_acc;
    logic w_is_lookup;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_is_lookup = (s_axis_tuser[ucrs_pkg::OFS_REQ +: ucrs_pkg::REQ_W] ==
                          ucrs_pkg::REQ_LOOKUP);

    // A stalled result holds
    `UCRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // Table writes and ignored requests free the input the next cycle
    `UCRS_ASSERT_NEXT(a_write_one_cycle, i_clk, i_rst_n, w_in_acc && !w_is_lookup, s_axis_tready, "write request kept input stalled")

    // A lookup occupies the search engine
    `UCRS_ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, w_in_acc && w_is_lookup, !s_axis_tready, "request taken during a lookup")

    // A new result only comes out of a running lookup
    `UCRS_ASSERT(a_result_from_search, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without a running lookup")

endmodule

bind unicode_category_range_search ucrs_checker u_ucrs_checker (.*);
